/* hw/rtl/thrc_pkg.sv */
// Package for the raw temperature and humidity conversion block.
// Holds the request, result and coefficient types, register indexes and constants.
// No dependencies; every other file of the block imports it.
package thrc_pkg;

    localparam int COEF_W = 48;
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;
    localparam int LATENCY = 6;

    localparam logic [2:0] REG_TEMP_OFFSET = 3'd0;
    localparam logic [2:0] REG_TEMP_SLOPE  = 3'd1;
    localparam logic [2:0] REG_HUM_OFFSET  = 3'd2;
    localparam logic [2:0] REG_HUM_LINEAR  = 3'd3;
    localparam logic [2:0] REG_HUM_SQUARE  = 3'd4;
    localparam logic [2:0] REG_COMP_BASE   = 3'd5;
    localparam logic [2:0] REG_COMP_SLOPE  = 3'd6;

    localparam logic signed [COEF_W-1:0] RST_TEMP_OFFSET = -48'sd172228188570;
    localparam logic signed [COEF_W-1:0] RST_TEMP_SLOPE  = 48'sd42949673;
    localparam logic signed [COEF_W-1:0] RST_HUM_OFFSET  = -48'sd8790939061;
    localparam logic signed [COEF_W-1:0] RST_HUM_LINEAR  = 48'sd157625300;
    localparam logic signed [COEF_W-1:0] RST_HUM_SQUARE  = -48'sd6853;
    localparam logic signed [COEF_W-1:0] RST_COMP_BASE   = 48'sd42949673;
    localparam logic signed [COEF_W-1:0] RST_COMP_SLOPE  = 48'sd343597;

    // Twenty-five degrees with 32 fractional bits.
    localparam logic signed [63:0] TEMP_25 = 64'sd107374182400;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [13:0] raw_temp;
        logic [11:0] raw_hum;
    } thrc_req_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] humidity;
        logic               saturated;
    } thrc_rsp_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] d1;
        logic signed [COEF_W-1:0] d2;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
        logic signed [COEF_W-1:0] t1;
        logic signed [COEF_W-1:0] t2;
    } thrc_coef_t;

    typedef struct packed {
        logic               valid;
        logic signed [62:0] pp_hh;
        logic signed [63:0] pp_hl;
        logic signed [63:0] pp_lh;
        logic        [62:0] pp_ll;
        logic signed [60:0] lin;
        logic signed [72:0] quad;
        logic signed [31:0] temperature;
        logic               temp_sat;
    } thrc_part_t;

endpackage

/* hw/rtl/thrc_regs.sv */
// Coefficient register file behind the APB-style configuration port.
// Depends on thrc_pkg for the coefficient type, indexes and reset values.
module thrc_regs import thrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output thrc_coef_t        coef
);

    thrc_coef_t coef_reg;
    thrc_coef_t coef_next;
    logic [2:0] index;
    logic       wr_en;
    logic signed [COEF_W-1:0] wdata;

    assign pready = 1'b1;
    assign index  = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && pready;
    assign wdata  = $signed(pwdata[COEF_W-1:0]);

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_TEMP_OFFSET: coef_next.d1 = wdata;
                REG_TEMP_SLOPE:  coef_next.d2 = wdata;
                REG_HUM_OFFSET:  coef_next.c1 = wdata;
                REG_HUM_LINEAR:  coef_next.c2 = wdata;
                REG_HUM_SQUARE:  coef_next.c3 = wdata;
                REG_COMP_BASE:   coef_next.t1 = wdata;
                REG_COMP_SLOPE:  coef_next.t2 = wdata;
                default:         coef_next = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_TEMP_OFFSET: prdata = APB_DW'(coef_reg.d1);
            REG_TEMP_SLOPE:  prdata = APB_DW'(coef_reg.d2);
            REG_HUM_OFFSET:  prdata = APB_DW'(coef_reg.c1);
            REG_HUM_LINEAR:  prdata = APB_DW'(coef_reg.c2);
            REG_HUM_SQUARE:  prdata = APB_DW'(coef_reg.c3);
            REG_COMP_BASE:   prdata = APB_DW'(coef_reg.t1);
            REG_COMP_SLOPE:  prdata = APB_DW'(coef_reg.t2);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.d1 <= RST_TEMP_OFFSET;
            coef_reg.d2 <= RST_TEMP_SLOPE;
            coef_reg.c1 <= RST_HUM_OFFSET;
            coef_reg.c2 <= RST_HUM_LINEAR;
            coef_reg.c3 <= RST_HUM_SQUARE;
            coef_reg.t1 <= RST_COMP_BASE;
            coef_reg.t2 <= RST_COMP_SLOPE;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

/* hw/rtl/thrc_poly.sv */
// Front three pipeline stages: coefficient products, exact temperature and
// the partial products of the compensation term. Depends on thrc_pkg.
module thrc_poly import thrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  thrc_req_t  req,
    input  thrc_coef_t coef,
    output thrc_part_t part
);

    // Stage one.
    logic               v1_reg;
    logic signed [62:0] pt_reg;
    logic signed [60:0] pf_reg;
    logic signed [60:0] lin1_reg;
    logic        [23:0] sq_reg;
    logic signed [14:0] rt_s;
    logic signed [12:0] rh_s;

    // Stage two.
    logic               v2_reg;
    logic signed [62:0] t_reg;
    logic signed [63:0] tm_reg;
    logic signed [61:0] f_reg;
    logic signed [60:0] lin2_reg;
    logic signed [72:0] quad2_reg;

    // Stage three.
    logic       v3_reg;
    thrc_part_t part_reg;
    thrc_part_t part_next;
    logic       t_fits;

    assign rt_s = $signed({1'b0, req.raw_temp});
    assign rh_s = $signed({1'b0, req.raw_hum});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg   <= 63'(coef.d2) * 63'(rt_s);
        pf_reg   <= 61'(coef.t2) * 61'(rh_s);
        lin1_reg <= 61'(coef.c2) * 61'(rh_s);
        sq_reg   <= 24'(req.raw_hum) * 24'(req.raw_hum);

        t_reg     <= 63'(coef.d1) + pt_reg;
        tm_reg    <= 64'(coef.d1) + 64'(pt_reg) - TEMP_25;
        f_reg     <= 62'(coef.t1) + 62'(pf_reg);
        lin2_reg  <= lin1_reg;
        quad2_reg <= 73'(coef.c3) * 73'($signed({1'b0, sq_reg}));

        part_reg  <= part_next;
    end

    assign t_fits = (&t_reg[62:47]) || !(|t_reg[62:47]);

    always_comb
    begin
        part_next.valid = v2_reg;
        part_next.pp_hh = 63'($signed(tm_reg[63:32])) * 63'($signed(f_reg[61:31]));
        part_next.pp_hl = 64'($signed(tm_reg[63:32])) * 64'($signed({1'b0, f_reg[30:0]}));
        part_next.pp_lh = 64'($signed({1'b0, tm_reg[31:0]})) * 64'($signed(f_reg[61:31]));
        part_next.pp_ll = 63'(tm_reg[31:0]) * 63'(f_reg[30:0]);
        part_next.lin   = lin2_reg;
        part_next.quad  = quad2_reg;
        part_next.temp_sat = !t_fits;
        if (t_fits)
        begin
            part_next.temperature = $signed(t_reg[47:16]);
        end
        else
        begin
            part_next.temperature = t_reg[62] ? $signed(SAT_NEG) : $signed(SAT_POS);
        end
    end

    always_comb
    begin
        part = part_reg;
        part.valid = v3_reg;
    end

endmodule

/* hw/rtl/thrc_sum.sv */
// Back three pipeline stages: partial product and offset sums, the final
// humidity add, and floor and saturation to the result. Depends on thrc_pkg.
module thrc_sum import thrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  thrc_part_t part,
    input  thrc_coef_t coef,
    output logic       done,
    output thrc_rsp_t  rsp
);

    logic               v4_reg;
    logic        [127:0] prod_reg;
    logic        [127:0] offs_reg;
    logic signed [31:0] temp4_reg;
    logic               tsat4_reg;

    logic               v5_reg;
    logic        [127:0] h_reg;
    logic signed [31:0] temp5_reg;
    logic               tsat5_reg;

    logic               done_reg;
    thrc_rsp_t          rsp_reg;
    thrc_rsp_t          rsp_next;
    logic               h_fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= part.valid;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= (128'(part.pp_hh) <<< 63) + (128'(part.pp_hl) <<< 32)
                   + (128'(part.pp_lh) <<< 31) + 128'(part.pp_ll);
        offs_reg  <= (128'(coef.c1) <<< 32) + (128'(part.lin) <<< 32)
                   + (128'(part.quad) <<< 32);
        temp4_reg <= part.temperature;
        tsat4_reg <= part.temp_sat;

        h_reg     <= prod_reg + offs_reg;
        temp5_reg <= temp4_reg;
        tsat5_reg <= tsat4_reg;

        rsp_reg   <= rsp_next;
    end

    assign h_fits = (&h_reg[127:79]) || !(|h_reg[127:79]);

    always_comb
    begin
        rsp_next.temperature = temp5_reg;
        rsp_next.saturated   = tsat5_reg || !h_fits;
        if (h_fits)
        begin
            rsp_next.humidity = $signed(h_reg[79:48]);
        end
        else
        begin
            rsp_next.humidity = h_reg[127] ? $signed(SAT_NEG) : $signed(SAT_POS);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* hw/rtl/temp_humidity_raw_conversion.sv */
// Top level of the raw temperature and humidity conversion block.
// Instantiates thrc_regs, thrc_poly and thrc_sum; depends on thrc_pkg.
//
//   Channel   Handshake                  Payload
//   request   start, accepted if !busy   req   (raw_temp, raw_hum)
//   result    done strobe, one cycle     rsp   (temperature, humidity, saturated)
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A request is taken in every cycle in which start is high; busy stays low.
// Each result follows its request through the pipeline, one per request, in order.
// The depth is set by the six register stages of the multiply and sum path.
// Reset clears the pipeline valid bits and loads the default coefficients.
// The receiver cannot stall, so results are never held.
module temp_humidity_raw_conversion import thrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  thrc_req_t         req,
    output logic              done,
    output thrc_rsp_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    thrc_coef_t coef;
    thrc_part_t part;

    assign busy = 1'b0;

    thrc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    thrc_poly u_poly
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .req      (req),
        .coef     (coef),
        .part     (part)
    );

    thrc_sum u_sum
    (
        .clk   (clk),
        .rst_n (rst_n),
        .part  (part),
        .coef  (coef),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

/* hw/rtl/thrc_checker.sv */
// Port-level checker for the conversion block, bound to the top level.
// Depends on thrc_pkg for the result type and saturation codes.
module thrc_assertions import thrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input thrc_rsp_t rsp
);

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a pipeline that never stalls");

    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("request produced no result after six cycles");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without a request six cycles earlier");

    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.temperature != SAT_POS && rsp.temperature != SAT_NEG
              && rsp.humidity != SAT_POS && rsp.humidity != SAT_NEG)
        |-> !rsp.saturated)
        else $error("saturated set on a result with no clipped value");

endmodule

bind temp_humidity_raw_conversion thrc_assertions u_thrc_assertions
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
